/* rtl/core/rfor_pkg.sv */
// Shared types and constants for the rectangle fill and outline rasterizer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package rfor_pkg;

  localparam int DEF_MAX_SIDE  = 256;
  localparam int DEF_FRAC_BITS = 8;

  localparam int COORD_W = 20;
  localparam int CFG_W   = 9;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] TYPE_FILLED  = 8'd82;
  localparam logic [BYTE_W-1:0] TYPE_OUTLINE = 8'd114;

  localparam logic [CFG_W-1:0]  RST_WIDTH      = 9'd256;
  localparam logic [CFG_W-1:0]  RST_HEIGHT     = 9'd256;
  localparam logic [BYTE_W-1:0] RST_BACKGROUND = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_REJECT  = 2'd1,
    STS_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_BACKGROUND = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic sweep;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic rect_ok;
    logic sweep_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/rectangle_fill_outline_raster.sv */
// Top level of the rectangle fill and outline rasterizer.
// Instantiates rfor_ctrl and rfor_dp; uses rfor_pkg.
//
// One command is taken at a time and gives exactly one result beat. A read,
// an unused command or a rejected rectangle goes from accept straight to its
// done state. A draw first sweeps the in-use canvas (canvas_width *
// canvas_height pixels) and a clear all MAX_SIDE * MAX_SIDE pixels, since the
// sweep counters visit one canvas pixel per cycle through the single write port.
// Clear writes the whole store, draw only the in-use area. The canvas holds
// no defined data until the first clear. A finished result sits in the
// output register while the next command is accepted; while that result is
// stalled, the next command holds in its done state until the result is taken.
`default_nettype none

module rectangle_fill_outline_raster #(
  parameter int MAX_SIDE  = rfor_pkg::DEF_MAX_SIDE,
  parameter int FRAC_BITS = rfor_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [rfor_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic [rfor_pkg::BYTE_W-1:0]         rect_type_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_x_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_y_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_w_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_h_i,
  input  logic [rfor_pkg::BYTE_W-1:0]         draw_color_i,
  input  logic [7:0]                          read_col_i,
  input  logic [7:0]                          read_row_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [rfor_pkg::BYTE_W-1:0]         pixel_o
);

  rfor_pkg::ctl_cmd_t ctl;
  rfor_pkg::dp_sts_t  sts;

  rfor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_stall_o (in_stall_o)
  );

  rfor_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .rect_type_i  (rect_type_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .draw_color_i (draw_color_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .pixel_o      (pixel_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_pixel_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pixel_o != '0)) |-> (status_o == rfor_pkg::STS_OK))
    else $error("nonzero pixel with error status");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat appeared without a command in work");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.sweep |-> (in_stall_o && !ctl.load && !ctl.out_load))
    else $error("sweep overlaps accept or result load");

endmodule

`default_nettype wire

/* rtl/core/rfor_ctrl.sv */
// Controller state machine of the rasterizer: sequences accept, sweep and result.
// Depends on rfor_pkg for state, command and status types.
`default_nettype none

module rfor_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  input  rfor_pkg::dp_sts_t  sts_i,
  output rfor_pkg::ctl_cmd_t ctl_o,
  output logic               in_stall_o
);

  rfor_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfor_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ctl_o        = '0;
    in_stall_o   = 1'b1;
    case (state_q)
      rfor_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          case (rfor_pkg::cmd_e'(cmd_i))
            rfor_pkg::CMD_CLEAR: state_d = rfor_pkg::ST_CLEAR;
            rfor_pkg::CMD_DRAW: begin
              state_d = sts_i.rect_ok ? rfor_pkg::ST_DRAW : rfor_pkg::ST_DONE;
            end
            default: state_d = rfor_pkg::ST_DONE;
          endcase
        end
      end
      rfor_pkg::ST_CLEAR, rfor_pkg::ST_DRAW: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = rfor_pkg::ST_DONE;
        end
      end
      rfor_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = rfor_pkg::ST_IDLE;
        end
      end
      default: state_d = rfor_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rfor_dp.sv */
// Datapath of the rasterizer: config registers, canvas memory, pixel sweep
// counters, rectangle edge compares and the result register. Uses rfor_pkg.
`default_nettype none

module rfor_dp #(
  parameter int MAX_SIDE  = rfor_pkg::DEF_MAX_SIDE,
  parameter int FRAC_BITS = rfor_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [rfor_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [1:0]                          cmd_i,
  input  logic [rfor_pkg::BYTE_W-1:0]         rect_type_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_x_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_y_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_w_i,
  input  logic signed [rfor_pkg::COORD_W-1:0] rect_h_i,
  input  logic [rfor_pkg::BYTE_W-1:0]         draw_color_i,
  input  logic [7:0]                          read_col_i,
  input  logic [7:0]                          read_row_i,
  input  rfor_pkg::ctl_cmd_t                  ctl_i,
  output rfor_pkg::dp_sts_t                   sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [1:0]                          status_o,
  output logic [rfor_pkg::BYTE_W-1:0]         pixel_o
);

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int LIM_W  = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (LIM_W > rfor_pkg::CFG_W) ? LIM_W : rfor_pkg::CFG_W;
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = ((rfor_pkg::COORD_W + 2) > (SIDE_W + FRAC_BITS + 2)) ?
                          (rfor_pkg::COORD_W + 2) : (SIDE_W + FRAC_BITS + 2);
  localparam logic signed [CW-1:0] ONE_FIX = CW'(1) << FRAC_BITS;
  localparam logic [SIDE_W-1:0]    FULL_END = SIDE_W'(MAX_SIDE - 1);

  logic [rfor_pkg::CFG_W-1:0]  cfg_width_q, cfg_height_q;
  logic [rfor_pkg::BYTE_W-1:0] cfg_bg_q;

  logic [CMP_W-1:0]  cw_ext, ch_ext, cw_use, ch_use;
  logic              read_outside, type_ok, dims_pos, is_read;

  logic              clear_mode_q, filled_q, read_ok_q;
  logic [1:0]        res_status_q;
  logic [rfor_pkg::BYTE_W-1:0] color_q;
  logic [SIDE_W-1:0] col_q, row_q, col_end_q, row_end_q;
  logic signed [CW-1:0] x_q, x_one_q, right_q, right_one_q;
  logic signed [CW-1:0] y_q, y_one_q, bottom_q, bottom_one_q;
  logic signed [CW-1:0] px, py;
  logic              in_x, in_y, band_x, band_y, hit, col_last;

  logic [rfor_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [rfor_pkg::BYTE_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_en, rd_en;
  logic [rfor_pkg::BYTE_W-1:0] wr_data;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [rfor_pkg::BYTE_W-1:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= rfor_pkg::RST_WIDTH;
      cfg_height_q <= rfor_pkg::RST_HEIGHT;
      cfg_bg_q     <= rfor_pkg::RST_BACKGROUND;
    end else if (cfg_we_i) begin
      case (rfor_pkg::cfg_idx_e'(cfg_index_i))
        rfor_pkg::CFG_WIDTH:      cfg_width_q  <= cfg_data_i;
        rfor_pkg::CFG_HEIGHT:     cfg_height_q <= cfg_data_i;
        rfor_pkg::CFG_BACKGROUND: cfg_bg_q     <= cfg_data_i[rfor_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the in-use canvas size to 1..MAX_SIDE
  always_comb begin
    cw_ext = CMP_W'(cfg_width_q);
    ch_ext = CMP_W'(cfg_height_q);
    cw_use = (cw_ext == '0) ? CMP_W'(1) :
             (cw_ext > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : cw_ext;
    ch_use = (ch_ext == '0) ? CMP_W'(1) :
             (ch_ext > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : ch_ext;
  end

  assign read_outside = (CMP_W'(read_col_i) >= cw_use) || (CMP_W'(read_row_i) >= ch_use);
  assign type_ok  = (rect_type_i == rfor_pkg::TYPE_FILLED) ||
                    (rect_type_i == rfor_pkg::TYPE_OUTLINE);
  assign dims_pos = !rect_w_i[rfor_pkg::COORD_W-1] && (rect_w_i != '0) &&
                    !rect_h_i[rfor_pkg::COORD_W-1] && (rect_h_i != '0);
  assign is_read  = (cmd_i == rfor_pkg::CMD_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_mode_q <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      col_end_q    <= '0;
      row_end_q    <= '0;
      res_status_q <= rfor_pkg::STS_OK;
      read_ok_q    <= 1'b0;
    end else if (ctl_i.load) begin
      clear_mode_q <= (cmd_i == rfor_pkg::CMD_CLEAR);
      col_q        <= '0;
      row_q        <= '0;
      col_end_q    <= (cmd_i == rfor_pkg::CMD_CLEAR) ? FULL_END : SIDE_W'(cw_use - CMP_W'(1));
      row_end_q    <= (cmd_i == rfor_pkg::CMD_CLEAR) ? FULL_END : SIDE_W'(ch_use - CMP_W'(1));
      read_ok_q    <= is_read && !read_outside;
      if ((cmd_i == rfor_pkg::CMD_DRAW) && !(type_ok && dims_pos)) begin
        res_status_q <= rfor_pkg::STS_REJECT;
      end else if (is_read && read_outside) begin
        res_status_q <= rfor_pkg::STS_OUTSIDE;
      end else begin
        res_status_q <= rfor_pkg::STS_OK;
      end
    end else if (ctl_i.sweep) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + SIDE_W'(1);
      end else begin
        col_q <= col_q + SIDE_W'(1);
      end
    end
  end

  // rectangle edges and border band limits, loaded on every accepted command
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      filled_q     <= (rect_type_i == rfor_pkg::TYPE_FILLED);
      color_q      <= draw_color_i;
      x_q          <= CW'(rect_x_i);
      x_one_q      <= CW'(rect_x_i) + ONE_FIX;
      right_q      <= CW'(rect_x_i) + CW'(rect_w_i);
      right_one_q  <= CW'(rect_x_i) + CW'(rect_w_i) - ONE_FIX;
      y_q          <= CW'(rect_y_i);
      y_one_q      <= CW'(rect_y_i) + ONE_FIX;
      bottom_q     <= CW'(rect_y_i) + CW'(rect_h_i);
      bottom_one_q <= CW'(rect_y_i) + CW'(rect_h_i) - ONE_FIX;
    end
  end

  assign col_last = (col_q == col_end_q);
  assign px       = $signed(CW'(col_q) << FRAC_BITS);
  assign py       = $signed(CW'(row_q) << FRAC_BITS);
  assign in_x     = (px >= x_q) && (px <= right_q);
  assign in_y     = (py >= y_q) && (py <= bottom_q);
  assign band_x   = (px < x_one_q) || (px > right_one_q);
  assign band_y   = (py < y_one_q) || (py > bottom_one_q);
  assign hit      = in_x && in_y && (band_x || band_y || filled_q);

  assign wr_en   = ctl_i.sweep && (clear_mode_q || hit);
  assign wr_data = clear_mode_q ? cfg_bg_q : color_q;
  assign wr_addr = ADDR_W'(32'(row_q) * MAX_SIDE + 32'(col_q));
  assign rd_en   = ctl_i.load && is_read;
  assign rd_addr = ADDR_W'(32'(read_row_i) * MAX_SIDE + 32'(read_col_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_q <= res_status_q;
      pixel_q  <= read_ok_q ? rd_data_q : '0;
    end
  end

  assign sts_o.rect_ok    = type_ok && dims_pos;
  assign sts_o.sweep_last = col_last && (row_q == row_end_q);
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pixel_o     = pixel_q;

endmodule

`default_nettype wire
